>>> hw/rtl/ppfm_pkg.sv
// Shared constants for the pulse period frequency meter.
// No dependencies; imported by pulse_period_frequency_meter and ppfm_checker.
`default_nettype none
package ppfm_pkg;

   localparam int RING_DEPTH = 16;
   localparam int IDX_W      = $clog2(RING_DEPTH);

   localparam int STAMP_W    = 32;
   localparam int CLOCK_W    = 30;
   localparam int FREQ_W     = 38;
   localparam int COUNT_W    = 32;

   // ring sum never wraps: below RING_DEPTH * 2^32
   localparam int SUM_W      = STAMP_W + IDX_W;
   // clock_hz * RING_DEPTH * 256
   localparam int NUM_W      = CLOCK_W + IDX_W + 8;
   localparam int CNT_W      = $clog2(NUM_W + 1);

   localparam logic [FREQ_W-1:0] FREQ_MAX = {FREQ_W{1'b1}};

   // input kind carried on tuser
   localparam logic FUNC_EDGE = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   // register indexes (byte address bit 2)
   localparam logic REG_CLOCK_HZ = 1'b0;
   localparam logic REG_ENABLE   = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_UPDATE = 4'b0010,
      ST_DIV    = 4'b0100,
      ST_DONE   = 4'b1000
   } state_type;

endpackage
`default_nettype wire

>>> hw/rtl/ppfm_ram.sv
// Generic simple dual-port RAM with a registered read port.
// No dependencies.
`default_nettype none
module ppfm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> hw/rtl/pulse_period_frequency_meter.sv
// Pulse period frequency meter: top level with control, ring sum and divider.
// Depends on ppfm_pkg and ppfm_ram.
//
// Usage
//   req_*  : input words. tuser = func (0 edge capture, 1 report tick),
//            tdata = capture timer value at the edge.
//   rsp_*  : one word per report tick while enabled: frequency in hertz
//            with 8 fraction bits and the edge count since the last report;
//            tuser flags an empty ring (frequency then reads 0).
//   csr_*  : APB registers, clock_hz at 0x0 and enable at 0x4.
// Sequence
//   An edge word: in IDLE the old ring entry is read from the RAM,
//   then in UPDATE the new interval is written and the running sum corrected.
//   A report tick goes from IDLE through DIV to DONE; DIV is the restoring divider
//   that produces one quotient bit a cycle, and an empty ring skips it.
//   A disabled tick is taken in IDLE and gives no result word.
// Reset
//   Synchronous. Ring valid bits, running sum, slot, previous time and
//   edge count clear at once, so the ring reads as all zero; no sweep.
// Stalls
//   The result sits in an output register; further words are accepted
//   while it waits. A second report stalls in its last cycle until the
//   first result is taken.
`default_nettype none
module pulse_period_frequency_meter
   import ppfm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // input words
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] capture_time
   input  wire logic        req_tuser,   // [0] func
   // result words
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [71:0] rsp_tdata,   // [37:0] frequency_q8, [69:38] edge_count
   output logic             rsp_tuser,   // [0] no_data
   // configuration
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready
);

   state_type state_ff, state_in;

   logic [CLOCK_W-1:0]    clock_hz_ff, clock_hz_in;
   logic                  enable_ff, enable_in;

   logic [IDX_W-1:0]      slot_ff, slot_in;
   logic [STAMP_W-1:0]    prev_ff, prev_in;
   logic [STAMP_W-1:0]    interval_ff, interval_in;
   logic [COUNT_W-1:0]    edges_ff, edges_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [RING_DEPTH-1:0] valid_ff, valid_in;

   logic [NUM_W-1:0]      num_ff, num_in;
   logic [NUM_W-1:0]      quo_ff, quo_in;
   logic [SUM_W-1:0]      rem_ff, rem_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  nodata_ff, nodata_in;

   logic                  out_valid_ff, out_valid_in;
   logic [FREQ_W-1:0]     out_freq_ff, out_freq_in;
   logic [COUNT_W-1:0]    out_count_ff, out_count_in;
   logic                  out_nodata_ff, out_nodata_in;

   logic                  accept;
   logic                  csr_write;
   logic                  ram_wr_en;
   logic                  ram_rd_en;
   logic [STAMP_W-1:0]    ram_rd_data;
   logic [STAMP_W-1:0]    old_interval;
   logic [SUM_W:0]        rem_shift;
   logic                  rem_ge;
   logic                  out_free;
   logic [FREQ_W-1:0]     freq_sat;

   ppfm_ram #(
      .WIDTH (STAMP_W),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (slot_ff),
      .wr_data (interval_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (slot_ff),
      .rd_data (ram_rd_data)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign ram_rd_en  = accept && (req_tuser == FUNC_EDGE);
   assign ram_wr_en  = (state_ff == ST_UPDATE);

   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   always_comb begin
      case (csr_paddr[2])
         REG_CLOCK_HZ: csr_prdata = {{(32-CLOCK_W){1'b0}}, clock_hz_ff};
         REG_ENABLE:   csr_prdata = {31'b0, enable_ff};
         default:      csr_prdata = '0;
      endcase
   end

   // entry never written since reset reads as zero
   assign old_interval = valid_ff[slot_ff] ? ram_rd_data : '0;

   // restoring divide step
   assign rem_shift = {rem_ff, num_ff[NUM_W-1]};
   assign rem_ge    = (rem_shift >= {1'b0, sum_ff});

   assign out_free  = !out_valid_ff || rsp_tready;
   assign freq_sat  = (|quo_ff[NUM_W-1:FREQ_W]) ? FREQ_MAX : quo_ff[FREQ_W-1:0];

   always_comb begin
      state_in      = state_ff;
      clock_hz_in   = clock_hz_ff;
      enable_in     = enable_ff;
      slot_in       = slot_ff;
      prev_in       = prev_ff;
      interval_in   = interval_ff;
      edges_in      = edges_ff;
      sum_in        = sum_ff;
      valid_in      = valid_ff;
      num_in        = num_ff;
      quo_in        = quo_ff;
      rem_in        = rem_ff;
      cnt_in        = cnt_ff;
      nodata_in     = nodata_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_freq_in   = out_freq_ff;
      out_count_in  = out_count_ff;
      out_nodata_in = out_nodata_ff;

      if (csr_write) begin
         case (csr_paddr[2])
            REG_CLOCK_HZ: clock_hz_in = csr_pwdata[CLOCK_W-1:0];
            REG_ENABLE:   enable_in   = csr_pwdata[0];
            default:      ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_tuser == FUNC_EDGE) begin
                  interval_in = req_tdata - prev_ff;
                  prev_in     = req_tdata;
                  edges_in    = edges_ff + COUNT_W'(1);
                  state_in    = ST_UPDATE;
               end else if (enable_ff) begin
                  num_in    = NUM_W'(clock_hz_ff) * NUM_W'(RING_DEPTH * 256);
                  quo_in    = '0;
                  rem_in    = '0;
                  cnt_in    = CNT_W'(NUM_W);
                  nodata_in = (sum_ff == '0);
                  state_in  = (sum_ff == '0) ? ST_DONE : ST_DIV;
               end
            end
         end
         ST_UPDATE: begin
            sum_in            = sum_ff - SUM_W'(old_interval) + SUM_W'(interval_ff);
            valid_in[slot_ff] = 1'b1;
            slot_in = (slot_ff == IDX_W'(RING_DEPTH - 1)) ? '0 : slot_ff + IDX_W'(1);
            state_in = ST_IDLE;
         end
         ST_DIV: begin
            rem_in = rem_ge ? SUM_W'(rem_shift - {1'b0, sum_ff}) : rem_shift[SUM_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], rem_ge};
            num_in = {num_ff[NUM_W-2:0], 1'b0};
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_freq_in   = nodata_ff ? '0 : freq_sat;
               out_count_in  = edges_ff;
               out_nodata_in = nodata_ff;
               edges_in      = '0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         clock_hz_ff  <= CLOCK_W'(1);
         enable_ff    <= 1'b0;
         slot_ff      <= '0;
         prev_ff      <= '0;
         edges_ff     <= '0;
         sum_ff       <= '0;
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clock_hz_ff  <= clock_hz_in;
         enable_ff    <= enable_in;
         slot_ff      <= slot_in;
         prev_ff      <= prev_in;
         edges_ff     <= edges_in;
         sum_ff       <= sum_in;
         valid_ff     <= valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      interval_ff   <= interval_in;
      num_ff        <= num_in;
      quo_ff        <= quo_in;
      rem_ff        <= rem_in;
      cnt_ff        <= cnt_in;
      nodata_ff     <= nodata_in;
      out_freq_ff   <= out_freq_in;
      out_count_ff  <= out_count_in;
      out_nodata_ff <= out_nodata_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(72 - FREQ_W - COUNT_W){1'b0}}, out_count_ff, out_freq_ff};
   assign rsp_tuser  = out_nodata_ff;

endmodule
`default_nettype wire

>>> hw/rtl/ppfm_checker.sv
// Port-level checks for the pulse period frequency meter, bound to the top.
// Depends on ppfm_pkg and pulse_period_frequency_meter.
`default_nettype none
module ppfm_checker
   import ppfm_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        req_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [71:0] rsp_tdata,
   input wire logic        rsp_tuser
);

   // a waiting result word is not dropped
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result word dropped while stalled");

   // an empty ring always reports zero frequency
   a_nodata_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[FREQ_W-1:0] == '0)
      else $error("no_data word with non-zero frequency");

   // no result straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result word after reset");

   // an edge word occupies the ring for its write-back cycle
   a_edge_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == FUNC_EDGE) |=> !req_tready)
      else $error("input taken during ring write-back");

endmodule

bind pulse_period_frequency_meter ppfm_checker u_ppfm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire
